FILE: rtl/core/itns_pkg.sv
// itns_pkg: shared types and constants for the interval table nearest search core
// used by itns_alu, itns_store and interval_table_nearest_search_core
// no dependencies
package itns_pkg;

  // fixed field widths of the item ports
  localparam int unsigned ROW_W   = 6;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned CNT_W   = IDX_W + 1;

  // largest row and entry counts the item fields can address
  localparam int unsigned ROW_MAX = 64;
  localparam int unsigned IDX_MAX = 1024;

  // item modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // operations of the shared arithmetic unit
  typedef enum logic [1:0] {
    OP_ADD_SAT,
    OP_ABS_DIFF,
    OP_CMP
  } itns_op_e;

  // search sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_COUNT,
    S_PROBE,
    S_FETCH,
    S_TEST_LO,
    S_TEST_HI,
    S_PREV_RD,
    S_PREV_FETCH,
    S_PREV_DA,
    S_PREV_DB,
    S_PREV_CMP,
    S_NEXT_RD,
    S_NEXT_FETCH,
    S_NEXT_DB,
    S_NEXT_CMP,
    S_DONE
  } itns_state_e;

endpackage

FILE: rtl/core/itns_alu.sv
// itns_alu: shared time arithmetic unit (saturating add, absolute difference, compare)
// one wide add and two wide subtracts computed side by side, purely combinational
// depends on itns_pkg
module itns_alu
  import itns_pkg::*;
#(
  parameter int unsigned TW = 48
) (
  input  itns_op_e        op_i,
  input  logic [TW-1:0]   x_i,
  input  logic [TW-1:0]   y_i,
  output logic [TW-1:0]   res_o,
  output logic            lt_o
);

  logic [TW:0] sum_w;
  logic [TW:0] diff_xy_w;
  logic [TW:0] diff_yx_w;

  assign sum_w     = {1'b0, x_i} + {1'b0, y_i};
  assign diff_xy_w = {1'b0, x_i} - {1'b0, y_i};
  assign diff_yx_w = {1'b0, y_i} - {1'b0, x_i};

  // borrow of x - y means x < y
  assign lt_o = diff_xy_w[TW];

  // result select
  always_comb begin
    unique case (op_i)
      OP_ADD_SAT:  res_o = sum_w[TW] ? {TW{1'b1}} : sum_w[TW-1:0];
      OP_ABS_DIFF: res_o = diff_xy_w[TW] ? diff_yx_w[TW-1:0] : diff_xy_w[TW-1:0];
      OP_CMP:      res_o = diff_xy_w[TW-1:0];
      default:     res_o = '0;
    endcase
  end

endmodule

FILE: rtl/core/itns_store.sv
// itns_store: interval entry memory and per-row count memory with row valid bits
// one write port and one registered read port on each memory
// depends on itns_pkg
module itns_store
  import itns_pkg::*;
#(
  parameter int unsigned RB = 6,
  parameter int unsigned IB = 10,
  parameter int unsigned TW = 48
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // entry and count write
  input  logic             wr_en_i,
  input  logic [RB-1:0]    wr_row_i,
  input  logic [IB-1:0]    wr_idx_i,
  input  logic [TW-1:0]    wr_start_i,
  input  logic [TW-1:0]    wr_len_i,
  input  logic [CNT_W-1:0] wr_count_i,
  // count read
  input  logic             cnt_rd_en_i,
  input  logic [RB-1:0]    cnt_rd_row_i,
  output logic [CNT_W-1:0] cnt_rd_o,
  // entry read
  input  logic             ent_rd_en_i,
  input  logic [RB-1:0]    ent_rd_row_i,
  input  logic [IB-1:0]    ent_rd_idx_i,
  output logic [TW-1:0]    ent_start_o,
  output logic [TW-1:0]    ent_len_o
);

  localparam int unsigned ROWS_P = 2 ** RB;
  localparam int unsigned ENTS_P = 2 ** (RB + IB);

  logic [2*TW-1:0]  ent_mem [ENTS_P];
  logic [CNT_W-1:0] cnt_mem [ROWS_P];
  logic [ROWS_P-1:0] row_vld_q;
  logic [2*TW-1:0]  ent_rd_q;
  logic [CNT_W-1:0] cnt_rd_q;

  // entry memory
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      ent_mem[{wr_row_i, wr_idx_i}] <= {wr_start_i, wr_len_i};
    end
    if (ent_rd_en_i) begin
      ent_rd_q <= ent_mem[{ent_rd_row_i, ent_rd_idx_i}];
    end
  end

  // count memory, unwritten rows read as zero through the valid bits
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      cnt_mem[wr_row_i] <= wr_count_i;
    end
    if (cnt_rd_en_i) begin
      cnt_rd_q <= row_vld_q[cnt_rd_row_i] ? cnt_mem[cnt_rd_row_i] : '0;
    end
  end

  // row valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (wr_en_i) begin
      row_vld_q[wr_row_i] <= 1'b1;
    end
  end

  assign cnt_rd_o    = cnt_rd_q;
  assign ent_start_o = ent_rd_q[2*TW-1:TW];
  assign ent_len_o   = ent_rd_q[TW-1:0];

endmodule

FILE: rtl/core/interval_table_nearest_search_core.sv
// interval_table_nearest_search_core: top level, sequencer around one shared time unit
// write transfer: stored in the cycle it is taken, ready again the next cycle
// query: a count read, then binary search probes (entry read, end sum, start and end compares),
//   then previous and next neighbour checks (read, distances, compare), then the output register;
//   an empty or missing row goes from the count read straight to the output register
// reset clears the sequencer, the output valid and the row valid bits; entries need no clear
module interval_table_nearest_search_core
  import itns_pkg::*;
#(
  parameter int unsigned ROWS      = 64,
  parameter int unsigned DEPTH     = 1024,
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 mode_i,
  input  logic [ROW_W-1:0]     row_i,
  input  logic [IDX_W-1:0]     entry_index_i,
  input  logic [TIME_BITS-1:0] interval_start_i,
  input  logic [TIME_BITS-1:0] interval_length_i,
  input  logic [TIME_BITS-1:0] query_time_i,
  // output channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 answer_valid_o,
  output logic [IDX_W-1:0]     found_index_o
);

  localparam int unsigned ROW_USE = (ROWS < ROW_MAX) ? ROWS : ROW_MAX;
  localparam int unsigned DEP_USE = (DEPTH < IDX_MAX) ? DEPTH : IDX_MAX;
  localparam int unsigned RB      = (ROW_USE > 1) ? $clog2(ROW_USE) : 1;
  localparam int unsigned IB      = $clog2(DEP_USE);
  localparam logic [ROW_W:0] ROW_LIM = (ROW_W + 1)'(ROW_USE);
  localparam logic [CNT_W-1:0] IDX_LIM = CNT_W'(DEP_USE);

  itns_state_e state_q, state_d;

  logic [TIME_BITS-1:0] t_q;
  logic [RB-1:0]        row_q;
  logic                 row_ok_q;
  logic [CNT_W-1:0]     a_q, a_d, b_q, b_d, pos_q, pos_d;
  logic [TIME_BITS-1:0] cur_start_q, cur_start_d, cur_end_q, cur_end_d;
  logic [TIME_BITS-1:0] nb_q, nb_d, da_q, da_d, db_q, db_d;
  logic                 ans_q, ans_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_ans_q;
  logic [IDX_W-1:0]     out_idx_q;
  logic                 out_load;

  logic                 in_xfer;
  logic                 row_ok_w;
  logic                 wr_en;
  logic                 cnt_rd_en;
  logic [CNT_W-1:0]     cnt_rd;
  logic                 ent_rd_en;
  logic [CNT_W-1:0]     ent_rd_pos;
  logic [TIME_BITS-1:0] ent_start, ent_len;

  itns_op_e             alu_op;
  logic [TIME_BITS-1:0] alu_x, alu_y, alu_res;
  logic                 alu_lt;

  logic [CNT_W-1:0]     pos_dec, pos_inc;
  logic [CNT_W:0]       sum_lo, sum_hi, sum_init;

  // input side decode
  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i & in_ready_o;
  assign row_ok_w   = ({1'b0, row_i} < ROW_LIM);
  assign wr_en      = in_xfer & (mode_i == MODE_WRITE) & row_ok_w &
                      ({1'b0, entry_index_i} < IDX_LIM);
  assign cnt_rd_en  = in_xfer & (mode_i == MODE_QUERY);

  // query payload capture
  always_ff @(posedge clk_i) begin
    if (cnt_rd_en) begin
      t_q      <= query_time_i;
      row_q    <= row_i[RB-1:0];
      row_ok_q <= row_ok_w;
    end
  end

  itns_store #(
    .RB (RB),
    .IB (IB),
    .TW (TIME_BITS)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_en_i      (wr_en),
    .wr_row_i     (row_i[RB-1:0]),
    .wr_idx_i     (entry_index_i[IB-1:0]),
    .wr_start_i   (interval_start_i),
    .wr_len_i     (interval_length_i),
    .wr_count_i   ({1'b0, entry_index_i} + CNT_W'(1)),
    .cnt_rd_en_i  (cnt_rd_en),
    .cnt_rd_row_i (row_i[RB-1:0]),
    .cnt_rd_o     (cnt_rd),
    .ent_rd_en_i  (ent_rd_en),
    .ent_rd_row_i (row_q),
    .ent_rd_idx_i (ent_rd_pos[IB-1:0]),
    .ent_start_o  (ent_start),
    .ent_len_o    (ent_len)
  );

  itns_alu #(
    .TW (TIME_BITS)
  ) u_alu (
    .op_i  (alu_op),
    .x_i   (alu_x),
    .y_i   (alu_y),
    .res_o (alu_res),
    .lt_o  (alu_lt)
  );

  // search bound arithmetic
  assign pos_dec  = pos_q - CNT_W'(1);
  assign pos_inc  = pos_q + CNT_W'(1);
  assign sum_lo   = {1'b0, a_q} + {1'b0, pos_dec};
  assign sum_hi   = {1'b0, pos_inc} + {1'b0, b_q};
  assign sum_init = {1'b0, cnt_rd - CNT_W'(1)};

  // sequencer next state and datapath control
  always_comb begin
    state_d     = state_q;
    a_d         = a_q;
    b_d         = b_q;
    pos_d       = pos_q;
    cur_start_d = cur_start_q;
    cur_end_d   = cur_end_q;
    nb_d        = nb_q;
    da_d        = da_q;
    db_d        = db_q;
    ans_d       = ans_q;
    out_load    = 1'b0;
    ent_rd_en   = 1'b0;
    ent_rd_pos  = pos_q;
    alu_op      = OP_CMP;
    alu_x       = t_q;
    alu_y       = cur_start_q;

    unique case (state_q)
      S_IDLE: begin
        if (cnt_rd_en) begin
          state_d = S_COUNT;
        end
      end
      S_COUNT: begin
        if (!row_ok_q || cnt_rd == '0) begin
          ans_d   = 1'b0;
          pos_d   = '0;
          state_d = S_DONE;
        end else begin
          ans_d   = 1'b1;
          a_d     = '0;
          b_d     = cnt_rd - CNT_W'(1);
          pos_d   = sum_init[CNT_W:1];
          state_d = S_PROBE;
        end
      end
      // binary search probe
      S_PROBE: begin
        ent_rd_en = 1'b1;
        state_d   = S_FETCH;
      end
      S_FETCH: begin
        alu_op      = OP_ADD_SAT;
        alu_x       = ent_start;
        alu_y       = ent_len;
        cur_start_d = ent_start;
        cur_end_d   = alu_res;
        state_d     = S_TEST_LO;
      end
      S_TEST_LO: begin
        // start beyond the time: go left
        alu_x = t_q;
        alu_y = cur_start_q;
        if (alu_lt) begin
          if (pos_q == '0) begin
            state_d = S_PREV_RD;
          end else if (pos_dec >= a_q) begin
            b_d     = pos_dec;
            pos_d   = sum_lo[CNT_W:1];
            state_d = S_PROBE;
          end else begin
            state_d = S_PREV_RD;
          end
        end else begin
          state_d = S_TEST_HI;
        end
      end
      S_TEST_HI: begin
        // end before the time: go right
        alu_x = cur_end_q;
        alu_y = t_q;
        if (alu_lt && b_q >= pos_inc) begin
          a_d     = pos_inc;
          pos_d   = sum_hi[CNT_W:1];
          state_d = S_PROBE;
        end else begin
          state_d = S_PREV_RD;
        end
      end
      // previous neighbour check
      S_PREV_RD: begin
        if (pos_q != '0) begin
          ent_rd_en  = 1'b1;
          ent_rd_pos = pos_dec;
          state_d    = S_PREV_FETCH;
        end else begin
          state_d = S_NEXT_RD;
        end
      end
      S_PREV_FETCH: begin
        alu_op  = OP_ADD_SAT;
        alu_x   = ent_start;
        alu_y   = ent_len;
        nb_d    = alu_res;
        state_d = S_PREV_DA;
      end
      S_PREV_DA: begin
        alu_op  = OP_ABS_DIFF;
        alu_y   = nb_q;
        da_d    = alu_res;
        state_d = S_PREV_DB;
      end
      S_PREV_DB: begin
        alu_op  = OP_ABS_DIFF;
        alu_y   = cur_start_q;
        db_d    = alu_res;
        state_d = S_PREV_CMP;
      end
      S_PREV_CMP: begin
        alu_x = da_q;
        alu_y = db_q;
        if (alu_lt) begin
          pos_d     = pos_dec;
          cur_end_d = nb_q;
        end
        state_d = S_NEXT_RD;
      end
      // next neighbour check
      S_NEXT_RD: begin
        if (pos_inc < cnt_rd) begin
          ent_rd_en  = 1'b1;
          ent_rd_pos = pos_inc;
          state_d    = S_NEXT_FETCH;
        end else begin
          state_d = S_DONE;
        end
      end
      S_NEXT_FETCH: begin
        alu_op  = OP_ABS_DIFF;
        alu_y   = ent_start;
        da_d    = alu_res;
        state_d = S_NEXT_DB;
      end
      S_NEXT_DB: begin
        alu_op  = OP_ABS_DIFF;
        alu_y   = cur_end_q;
        db_d    = alu_res;
        state_d = S_NEXT_CMP;
      end
      S_NEXT_CMP: begin
        alu_x = da_q;
        alu_y = db_q;
        if (alu_lt) begin
          pos_d = pos_inc;
        end
        state_d = S_DONE;
      end
      // hand the result to the output register
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // search datapath registers
  always_ff @(posedge clk_i) begin
    a_q         <= a_d;
    b_q         <= b_d;
    pos_q       <= pos_d;
    cur_start_q <= cur_start_d;
    cur_end_q   <= cur_end_d;
    nb_q        <= nb_d;
    da_q        <= da_d;
    db_q        <= db_d;
    ans_q       <= ans_d;
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_ans_q <= ans_q;
      out_idx_q <= pos_q[IDX_W-1:0];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign answer_valid_o = out_ans_q;
  assign found_index_o  = out_idx_q;

  // an invalid answer always carries index zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !answer_valid_o |-> found_index_o == '0)
    else $error("invalid answer with nonzero index");

  // every probe stays inside the loaded part of the row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PROBE |-> pos_q < cnt_rd)
    else $error("probe beyond row count");

  // a result appears only out of the final sequencer step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_DONE)
    else $error("result without a finished query");

  // a write transfer never starts a search
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && mode_i == MODE_WRITE |=> state_q == S_IDLE)
    else $error("write transfer left idle");

endmodule

FILE: sim/tb_interval_table_nearest_search_core.sv
// testbench for interval_table_nearest_search_core: loads sorted and unsorted rows,
// queries them under random input bursts and output stalls, checks every answer
// depends on itns_pkg and the core rtl only
`timescale 1ns / 100ps

module tb_interval_table_nearest_search_core;
  import itns_pkg::*;

  localparam int unsigned N_ROWS       = 64;
  localparam int unsigned N_DEPTH      = 1024;
  localparam int unsigned TIME_W       = 48;
  localparam int unsigned ITEM_TARGET  = 1700;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned HOLD_CYCLES  = 400;

  typedef logic [TIME_W-1:0] tick_t;
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] index;
  } answer_t;

  localparam tick_t T_MAX = '1;

  // mirror of the interval table and the answers still owed by the core
  class nearest_interval_board;
    bit [TIME_W-1:0] start_tab [N_ROWS][N_DEPTH];
    bit [TIME_W-1:0] len_tab   [N_ROWS][N_DEPTH];
    int unsigned     row_len    [N_ROWS];
    int unsigned     row_filled [N_ROWS];
    answer_t         pending [$];
    int unsigned     errors;

    // end of an interval, saturating at the top tick
    function tick_t interval_end(int unsigned row, int unsigned k);
      logic [TIME_W:0] sum;
      sum = {1'b0, start_tab[row][k]} + {1'b0, len_tab[row][k]};
      return sum[TIME_W] ? T_MAX : sum[TIME_W-1:0];
    endfunction

    function tick_t tick_dist(tick_t x, tick_t y);
      return (x > y) ? x - y : y - x;
    endfunction

    // binary search for a covering interval, then nearer neighbour steps
    function answer_t nearest_answer(int unsigned row, tick_t t);
      answer_t     ans;
      int unsigned cnt, lo, hi, pos;
      ans = '0;
      if (row >= N_ROWS || row_len[row] == 0) return ans;
      cnt = row_len[row];
      lo  = 0;
      hi  = cnt - 1;
      pos = (lo + hi) / 2;
      while (hi >= lo) begin
        pos = (lo + hi) / 2;
        if (start_tab[row][pos] > t) begin
          if (pos == 0) break;
          hi = pos - 1;
          continue;
        end
        if (interval_end(row, pos) < t) begin
          lo = pos + 1;
          continue;
        end
        break;
      end
      if (pos > 0) begin
        if (tick_dist(t, interval_end(row, pos - 1)) < tick_dist(t, start_tab[row][pos]))
          pos = pos - 1;
      end
      if (pos < cnt - 1) begin
        if (tick_dist(t, start_tab[row][pos + 1]) < tick_dist(t, interval_end(row, pos)))
          pos = pos + 1;
      end
      ans.hit   = 1'b1;
      ans.index = IDX_W'(pos);
      return ans;
    endfunction

    // apply one accepted input transfer
    function void note_transfer(logic mode, logic [ROW_W-1:0] row, logic [IDX_W-1:0] idx,
                                tick_t s, tick_t l, tick_t t);
      if (mode == MODE_WRITE) begin
        start_tab[row][idx] = s;
        len_tab[row][idx]   = l;
        row_len[row]        = int'(idx) + 1;
        if (int'(idx) == row_filled[row]) row_filled[row]++;
      end else begin
        pending.insert(pending.size(), nearest_answer(row, t));
      end
    endfunction

    // compare one accepted output transfer with the oldest owed answer
    function void check_answer(logic hit, logic [IDX_W-1:0] index);
      answer_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected answer hit=%0b index=%0d", $time, hit, index);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (hit !== want.hit) begin
        $display("%0t: answer_valid mismatch, expected %0b actual %0b", $time, want.hit, hit);
        errors++;
      end
      if (index !== want.index) begin
        $display("%0t: found_index mismatch, expected %0d actual %0d",
                 $time, want.index, index);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_n        = 1'b0;
  logic             in_valid     = 1'b0;
  logic             in_ready;
  logic             mode         = MODE_WRITE;
  logic [ROW_W-1:0] row          = '0;
  logic [IDX_W-1:0] entry_index  = '0;
  tick_t            ivl_start    = '0;
  tick_t            ivl_length   = '0;
  tick_t            query_time   = '0;
  logic             out_valid;
  logic             out_ready    = 1'b0;
  logic             answer_valid;
  logic [IDX_W-1:0] found_index;

  nearest_interval_board board = new();
  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned burst_left   = 0;
  int unsigned cycle_count  = 0;

  interval_table_nearest_search_core #(
    .ROWS      (N_ROWS),
    .DEPTH     (N_DEPTH),
    .TIME_BITS (TIME_W)
  ) u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .mode_i            (mode),
    .row_i             (row),
    .entry_index_i     (entry_index),
    .interval_start_i  (ivl_start),
    .interval_length_i (ivl_length),
    .query_time_i      (query_time),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .answer_valid_o    (answer_valid),
    .found_index_o     (found_index)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // output monitor
  always @(posedge clk_i) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      board.check_answer(answer_valid, found_index);
      results_seen <= results_seen + 1;
    end
  end

  // output stall pattern, with one long hold-off
  initial begin : answer_sink
    int unsigned phase_left;
    int unsigned style;
    int unsigned tick_no;
    bit          held;
    phase_left = 0;
    style      = 0;
    tick_no    = 0;
    held       = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk_i);
      tick_no++;
      if (!held && results_seen >= 30) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      if (phase_left == 0) begin
        style      = $urandom_range(0, 3);
        phase_left = $urandom_range(10, 150);
      end
      phase_left--;
      case (style)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 1) == 1);
        2:       out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= (tick_no % 3 != 0);
      endcase
    end
  end

  function automatic tick_t rand_tick();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[TIME_W-1:0];
  endfunction

  function automatic tick_t rand_scaled(int unsigned bits);
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    if (bits < 64) w = w & ((64'd1 << bits) - 64'd1);
    return w[TIME_W-1:0];
  endfunction

  // one input transfer, with burst and gap pacing
  task automatic send_item(logic m, logic [ROW_W-1:0] r, logic [IDX_W-1:0] idx,
                           tick_t s, tick_t l, tick_t t);
    int unsigned gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        gap        = 0;
        burst_left = $urandom_range(30, 80);
      end else begin
        gap        = $urandom_range(1, 8);
        burst_left = $urandom_range(1, 16);
      end
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    mode        <= m;
    row         <= r;
    entry_index <= idx;
    ivl_start   <= s;
    ivl_length  <= l;
    query_time  <= t;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    board.note_transfer(m, r, idx, s, l, t);
    items_sent++;
  endtask

  task automatic write_entry(int unsigned r, int unsigned idx, tick_t s, tick_t l);
    send_item(MODE_WRITE, ROW_W'(r), IDX_W'(idx), s, l, rand_tick());
  endtask

  task automatic query_at(int unsigned r, tick_t t);
    send_item(MODE_QUERY, ROW_W'(r), IDX_W'($urandom_range(0, N_DEPTH - 1)),
              rand_tick(), rand_tick(), t);
  endtask

  // query times around the edges of the row's intervals
  function automatic tick_t pick_time(int unsigned r);
    int unsigned n, k;
    tick_t       e;
    n = board.row_len[r];
    if (n == 0) return rand_tick();
    k = $urandom_range(0, n - 1);
    e = board.interval_end(r, k);
    case ($urandom_range(0, 7))
      0: return board.start_tab[r][k];
      1: return e;
      2: return board.start_tab[r][k] - 1'b1;
      3: return e + 1'b1;
      4: begin
        if (k + 1 < n) return e + (board.start_tab[r][k + 1] - e) / 2;
        return e + rand_scaled(8);
      end
      5: return rand_tick();
      6: return ($urandom_range(0, 1) == 1) ? T_MAX : '0;
      default: return board.start_tab[r][k] + rand_scaled(6);
    endcase
  endfunction

  // fill entries 0..n-1 of a row with intervals by rising start, which may wrap past the top tick
  task automatic load_sorted_row(int unsigned r, int unsigned n,
                                 int unsigned step_bits, int unsigned len_bits);
    tick_t s, l;
    case ($urandom_range(0, 7))
      0:       s = '0;
      7:       s = T_MAX - tick_t'(n * 16);
      default: s = rand_scaled(step_bits);
    endcase
    for (int unsigned k = 0; k < n; k++) begin
      l = ($urandom_range(0, 9) == 0) ? rand_tick() : rand_scaled(len_bits);
      write_entry(r, k, s, l);
      s = s + rand_scaled(step_bits);
    end
  endtask

  // stray queries and writes that break the sorted order
  task automatic noise_item();
    int unsigned r, lim;
    r = $urandom_range(0, N_ROWS - 1);
    case ($urandom_range(0, 3))
      0: query_at(r, pick_time(r));
      1: begin
        lim = board.row_filled[r];
        if (lim > N_DEPTH - 1) lim = N_DEPTH - 1;
        write_entry(r, $urandom_range(0, lim), rand_tick(), rand_tick());
      end
      2: begin
        if (board.row_len[r] > 1)
          write_entry(r, $urandom_range(0, board.row_len[r] - 2), rand_tick(), rand_scaled(20));
        else
          query_at(r, rand_tick());
      end
      default: query_at(r, rand_tick());
    endcase
  endtask

  // stimulus
  initial begin : stimulus
    int unsigned r, n, step_bits, len_bits;
    bit          big_done;
    big_done = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;

    // empty rows
    query_at(5, '0);
    query_at(63, T_MAX);
    // point interval, short interval, interval whose end saturates
    write_entry(0, 0, 48'd0, 48'd0);
    write_entry(0, 1, 48'd10, 48'd5);
    write_entry(0, 2, 48'd101, T_MAX);
    query_at(0, 48'd0);
    query_at(0, 48'd12);
    query_at(0, 48'd50);   // gap, previous end nearer
    query_at(0, 48'd58);   // gap, equal distance keeps the searched index
    query_at(0, 48'd90);
    query_at(0, T_MAX);
    write_entry(63, 0, T_MAX, T_MAX);
    query_at(63, '0);
    query_at(63, T_MAX);
    // rewrite entry zero shrinks the row to one entry
    write_entry(0, 0, 48'd5, 48'd1);
    query_at(0, 48'd200);
    // unsorted row
    write_entry(7, 0, 48'd500, 48'd10);
    write_entry(7, 1, 48'd20, 48'd5);
    write_entry(7, 2, 48'd300, 48'd0);
    query_at(7, 48'd25);
    query_at(7, 48'd400);

    // random phases: sorted loads with queries, a full row once, some noise
    while (items_sent < ITEM_TARGET) begin
      if (!big_done && items_sent >= 300) begin
        big_done = 1'b1;
        r = $urandom_range(1, N_ROWS - 2);
        load_sorted_row(r, N_DEPTH, 36, 36);
        repeat (60) query_at(r, pick_time(r));
      end else if ($urandom_range(0, 99) < 80) begin
        r = $urandom_range(0, N_ROWS - 1);
        case ($urandom_range(0, 15))
          0, 1:    n = $urandom_range(1, 2);
          2:       n = $urandom_range(40, 64);
          default: n = $urandom_range(3, 24);
        endcase
        case ($urandom_range(0, 2))
          0:       step_bits = 3;
          1:       step_bits = 12;
          default: step_bits = 40;
        endcase
        case ($urandom_range(0, 2))
          0:       len_bits = 2;
          1:       len_bits = 10;
          default: len_bits = 38;
        endcase
        load_sorted_row(r, n, step_bits, len_bits);
        repeat ($urandom_range(3, 10)) query_at(r, pick_time(r));
      end else begin
        repeat ($urandom_range(1, 4)) noise_item();
      end
    end
    in_valid <= 1'b0;

    // drain
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: interval_table_nearest_search_core.f
rtl/core/itns_pkg.sv
rtl/core/itns_alu.sv
rtl/core/itns_store.sv
rtl/core/interval_table_nearest_search_core.sv
sim/tb_interval_table_nearest_search_core.sv
